/* rtl/rotating_backup_record_store_macros.svh */
// assertion macros for the record store
`ifndef ROTATING_BACKUP_RECORD_STORE_MACROS_SVH
`define ROTATING_BACKUP_RECORD_STORE_MACROS_SVH
// property that must hold on every clock edge out of reset
`define RBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked through reset too
`define RBRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/rbrs_pkg.sv */
// ----------------------------------------------------------------------------
// rbrs_pkg
// types and codes shared by the record store modules
// ----------------------------------------------------------------------------
package rbrs_pkg;
  localparam logic [1:0] OP_STAGE   = 2'd0;
  localparam logic [1:0] OP_SAVE    = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_OFS = 2'd2;
  localparam logic [1:0] ST_NO_CELL = 2'd3;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_DEPTH  = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  localparam logic [7:0] ERASED     = 8'hFF;
  localparam int unsigned DEPTH_LIMIT = 86;
  localparam int unsigned HDR_BYTES = 3;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic [7:0] bad_cells;
    logic       last;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_CHECK, S_CELL, S_FWAIT, S_FREAD,
    S_SUM_RD, S_SUM_WAIT, S_SUM_ACC, S_HDR1, S_HDR2, S_VERDICT,
    S_NEXT, S_DECIDE, S_WDATA, S_WHDR1, S_WHDR2, S_WHDR0,
    S_RADDR, S_RWAIT, S_EMIT, S_RESULT
  } state_t;
endpackage

/* rtl/rbrs_stream_if.sv */
// ----------------------------------------------------------------------------
// rbrs_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface rbrs_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/rbrs_mem.sv */
// ----------------------------------------------------------------------------
// rbrs_mem
// single port byte memory, registered read
// ----------------------------------------------------------------------------
module rbrs_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/rotating_backup_record_store.sv */
// ----------------------------------------------------------------------------
// rotating_backup_record_store
// ring of checksummed backup cells kept in a byte store
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per command (stage byte, save, restore); opcode 3
//   is dropped with no result
//   out channel: one result beat per stage or save, one beat per data byte
//   on a restore, last marks the closing beat
//   cfg port: write region offset, depth and record length while idle
// timing
//   a stage passes through the result state before the next command is
//   accepted; the search reads only the freshness byte of a cell it skips
//   and the whole record and checksum of a cell it checksums, for each cell;
//   a save then writes the data bytes and header of the cell, a restore reads
//   each data byte through its address, wait and emit states on the single store port
// reset
//   after reset a clearing pass writes 0xFF to every store byte, one byte
//   a cycle; no command is taken meanwhile
// stalls
//   a result waits in the output register; the engine holds and no command
//   is taken until it has gone
// ----------------------------------------------------------------------------
`include "rotating_backup_record_store_macros.svh"

module rotating_backup_record_store #(
  parameter int unsigned STORE_BYTES = 4096,
  parameter int unsigned MAX_RECORD  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [4:0]  in_byte_index,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic        out_byte_valid,
  output logic [7:0]  out_bad_cells,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rbrs_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned SW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam int unsigned LEN_CAP = (MAX_RECORD < 32) ? MAX_RECORD : 32;
  // wide address arithmetic, covers offset plus 85 cells of 35 bytes
  localparam int unsigned XW = 17;

  // configuration registers
  logic [11:0] offset_r;
  logic [7:0]  depth_r;
  logic [5:0]  length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      depth_r  <= 8'd2;
      length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET: offset_r <= cfg_data;
        REG_DEPTH:  depth_r  <= cfg_data[7:0];
        REG_LENGTH: length_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // staging buffer, undefined until written
  logic [7:0] stage_mem [MAX_RECORD];
  logic [7:0] stage_q;
  logic       stage_we;
  logic [SW-1:0] stage_wa, stage_ra;

  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_mem[stage_wa] <= in_data_byte;
    end
    stage_q <= stage_mem[stage_ra];
  end

  // byte store
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  rbrs_mem #(.DEPTH(STORE_BYTES), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // engine registers
  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    idx_r, idx_nxt;       // cell under search
  logic [XW-1:0] base_r, base_nxt;     // byte address of that cell
  logic [5:0]    pos_r, pos_nxt;       // data byte position
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    fr_r, fr_nxt;         // freshness of current cell
  logic [7:0]    lo_r, lo_nxt;
  logic [7:0]    best_r, best_nxt;
  logic [7:0]    bestf_r, bestf_nxt;
  logic [7:0]    stale_r, stale_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          ovalid_r, ovalid_nxt;
  result_t       ores_r, ores_nxt;
  logic          rdone_r, rdone_nxt;   // closing beat of an operation issued

  logic [XW-1:0] cell_span;
  logic [XW-1:0] region_end;
  logic [XW-1:0] byte_addr;
  logic          fresher;
  logic [7:0]    d8;

  assign cell_span = XW'(HDR_BYTES) + XW'(length_r);
  assign region_end = XW'(offset_r) + XW'(depth_r) * cell_span;
  assign d8 = depth_r;

  always_comb begin
    fresher = 1'b0;
    if (bestf_r == ERASED) fresher = 1'b1;
    else if (fr_r > (ERASED - d8) && bestf_r < d8) fresher = 1'b0;
    else if (fr_r > bestf_r) fresher = 1'b1;
    else if (fr_r < d8 && bestf_r > (ERASED - d8)) fresher = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == AW'(STORE_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid && !ovalid_r) begin
          case (in_opcode)
            OP_STAGE:   state_nxt = S_RESULT;
            OP_SAVE,
            OP_RESTORE: state_nxt = S_CHECK;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (depth_r == 8'd0 || depth_r >= 8'(DEPTH_LIMIT) ||
            XW'(offset_r) >= XW'(STORE_BYTES) || length_r > 6'(LEN_CAP) ||
            region_end >= XW'(STORE_BYTES)) state_nxt = S_RESULT;
        else state_nxt = S_CELL;
      end
      S_CELL:    state_nxt = (idx_r == depth_r) ? S_DECIDE : S_FWAIT;
      S_FWAIT:   state_nxt = S_FREAD;
      S_FREAD:   state_nxt = S_SUM_RD;
      S_SUM_RD: begin
        if (fr_r == ERASED || !fresher) state_nxt = S_NEXT;
        else if (pos_r == length_r) state_nxt = S_HDR1;
        else state_nxt = S_SUM_WAIT;
      end
      S_SUM_WAIT: state_nxt = S_SUM_ACC;
      S_SUM_ACC:  state_nxt = (pos_r + 6'd1 == length_r) ? S_HDR1 : S_SUM_WAIT;
      S_HDR1:     state_nxt = S_HDR2;
      S_HDR2:     state_nxt = S_VERDICT;
      S_VERDICT:  state_nxt = S_NEXT;
      S_NEXT:     state_nxt = S_CELL;
      S_DECIDE: begin
        if (op_r == OP_SAVE) state_nxt = (length_r == 6'd0) ? S_WHDR1 : S_WDATA;
        else if (best_r == depth_r || length_r == 6'd0) state_nxt = S_RESULT;
        else state_nxt = S_RADDR;
      end
      S_WDATA:  state_nxt = (pos_r == length_r) ? S_WHDR1 : S_WDATA;
      S_WHDR1:  state_nxt = S_WHDR2;
      S_WHDR2:  state_nxt = S_WHDR0;
      S_WHDR0:  state_nxt = S_RESULT;
      S_RADDR:  state_nxt = S_RWAIT;
      S_RWAIT:  state_nxt = S_EMIT;
      S_EMIT:   state_nxt = (!ovalid_r || out_ready) ?
                  ((pos_r + 6'd1 == length_r) ? S_RESULT : S_RADDR) : S_EMIT;
      S_RESULT: state_nxt = (!ovalid_r || out_ready) ? S_IDLE : S_RESULT;
      default:  state_nxt = S_IDLE;
    endcase
    if (state_r == S_RESULT && rdone_r && (!ovalid_r || out_ready)) state_nxt = S_IDLE;
  end

  // datapath and outputs
  always_comb begin
    op_nxt = op_r; idx_nxt = idx_r; base_nxt = base_r; pos_nxt = pos_r;
    sum_nxt = sum_r; fr_nxt = fr_r; lo_nxt = lo_r; best_nxt = best_r;
    bestf_nxt = bestf_r; stale_nxt = stale_r; clr_nxt = clr_r;
    ovalid_nxt = ovalid_r && !out_ready; ores_nxt = ores_r;
    rdone_nxt = rdone_r;
    mem_we = 1'b0; byte_addr = base_r; mem_wdata = ERASED;
    stage_we = 1'b0; stage_wa = SW'(in_byte_index); stage_ra = pos_r[SW-1:0];
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1; byte_addr = XW'(clr_r); clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        // a waiting result holds off the next command
        in_ready = !ovalid_r; rdone_nxt = 1'b0;
        if (in_valid && in_ready) begin
          op_nxt = in_opcode;
          if (in_opcode == OP_STAGE) begin
            stage_we = (32'(in_byte_index) < MAX_RECORD);
            ores_nxt = '{status: ST_OK, read_byte: 8'd0, byte_valid: 1'b0,
                         bad_cells: 8'd0, last: 1'b1};
          end
        end
      end
      S_CHECK: begin
        idx_nxt = '0; base_nxt = XW'(offset_r); best_nxt = depth_r;
        bestf_nxt = ERASED; stale_nxt = '0;
        ores_nxt = '{status: ST_OK, read_byte: 8'd0, byte_valid: 1'b0,
                     bad_cells: 8'd0, last: 1'b1};
        if (depth_r == 8'd0 || depth_r >= 8'(DEPTH_LIMIT)) ores_nxt.status = ST_BAD_LEN;
        else if (XW'(offset_r) >= XW'(STORE_BYTES)) ores_nxt.status = ST_BAD_OFS;
        else if (length_r > 6'(LEN_CAP) || region_end >= XW'(STORE_BYTES))
          ores_nxt.status = ST_BAD_LEN;
      end
      S_CELL:  byte_addr = base_r;
      S_FWAIT: byte_addr = base_r;
      S_FREAD: begin
        fr_nxt = mem_rdata; sum_nxt = {8'd0, mem_rdata}; pos_nxt = '0;
        byte_addr = base_r + XW'(HDR_BYTES);
      end
      // an empty record goes straight to the checksum bytes
      S_SUM_RD: byte_addr = (length_r == 6'd0) ? base_r + XW'(1) :
                            base_r + XW'(HDR_BYTES);
      S_SUM_WAIT: byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r);
      S_SUM_ACC: begin
        sum_nxt = sum_r + {8'd0, mem_rdata}; pos_nxt = pos_r + 6'd1;
        byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r) + XW'(1);
        if (pos_r + 6'd1 == length_r) byte_addr = base_r + XW'(1);
      end
      S_HDR1: begin
        lo_nxt = mem_rdata; byte_addr = base_r + XW'(2);
      end
      S_HDR2: byte_addr = base_r + XW'(2);
      S_VERDICT: begin
        if ({mem_rdata, lo_r} == sum_r) begin
          best_nxt = idx_r; bestf_nxt = fr_r;
        end else begin
          stale_nxt = stale_r + 8'd1; mem_we = 1'b1; byte_addr = base_r;
        end
      end
      S_NEXT: begin
        idx_nxt = idx_r + 8'd1; base_nxt = base_r + cell_span;
      end
      S_DECIDE: begin
        pos_nxt = '0; sum_nxt = '0;
        if (op_r == OP_SAVE) begin
          if (best_r != depth_r) begin
            idx_nxt = (best_r + 8'd1 >= depth_r) ? 8'd0 : best_r + 8'd1;
            fr_nxt = (bestf_r + 8'd1 >= ERASED) ? 8'd0 : bestf_r + 8'd1;
          end else begin
            idx_nxt = 8'd0; fr_nxt = 8'd0;
          end
          sum_nxt = {8'd0, (best_r != depth_r) ?
                    ((bestf_r + 8'd1 >= ERASED) ? 8'd0 : bestf_r + 8'd1) : 8'd0};
          base_nxt = XW'(offset_r) + XW'(idx_nxt) * cell_span;
          ores_nxt.bad_cells = stale_r;
        end else begin
          base_nxt = XW'(offset_r) + XW'(best_r) * cell_span;
          ores_nxt.bad_cells = (best_r == depth_r) ? 8'hFF : stale_r;
          ores_nxt.status = (best_r == depth_r) ? ST_NO_CELL : ST_OK;
        end
      end
      S_WDATA: begin
        // staging read in flight on pos_r; write the byte read last cycle
        if (pos_r != 6'd0) begin
          mem_we = 1'b1; mem_wdata = stage_q;
          byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r) - XW'(1);
          sum_nxt = sum_r + {8'd0, stage_q};
        end
        pos_nxt = pos_r + 6'd1;
      end
      S_WHDR1: begin
        mem_we = 1'b1; byte_addr = base_r + XW'(1); mem_wdata = sum_r[7:0];
      end
      S_WHDR2: begin
        mem_we = 1'b1; byte_addr = base_r + XW'(2); mem_wdata = sum_r[15:8];
      end
      S_WHDR0: begin
        mem_we = 1'b1; byte_addr = base_r; mem_wdata = fr_r;
      end
      S_RADDR: byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r);
      S_RWAIT: byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r);
      S_EMIT: begin
        byte_addr = base_r + XW'(HDR_BYTES) + XW'(pos_r);
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ores_nxt.read_byte = mem_rdata; ores_nxt.byte_valid = 1'b1;
          ores_nxt.last = (pos_r + 6'd1 == length_r);
          pos_nxt = pos_r + 6'd1;
          rdone_nxt = (pos_r + 6'd1 == length_r);
        end
      end
      S_RESULT: begin
        if (!rdone_r && (!ovalid_r || out_ready)) begin
          ovalid_nxt = 1'b1;
          ores_nxt.read_byte = 8'd0; ores_nxt.byte_valid = 1'b0; ores_nxt.last = 1'b1;
          rdone_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mem_addr = byte_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      rdone_r  <= 1'b0;
      op_r     <= OP_STAGE;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      rdone_r  <= rdone_nxt;
      op_r     <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; base_r <= base_nxt; pos_r <= pos_nxt; sum_r <= sum_nxt;
    fr_r <= fr_nxt; lo_r <= lo_nxt; best_r <= best_nxt; bestf_r <= bestf_nxt;
    stale_r <= stale_nxt; ores_r <= ores_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ores_r.status;
  assign out_read_byte   = ores_r.read_byte;
  assign out_byte_valid  = ores_r.byte_valid;
  assign out_bad_cells   = ores_r.bad_cells;
  assign out_last        = ores_r.last;

  `RBRS_ASSERT(a_no_take_busy, (in_ready |-> state_r == S_IDLE), "input taken while busy")
  `RBRS_ASSERT(a_hold_stall, (out_valid && !out_ready |=> out_valid && $stable(ores_r)),
    "result dropped under stall")
  `RBRS_ASSERT(a_byte_valid, (out_valid && !out_byte_valid |-> out_read_byte == 8'd0),
    "stray read byte")
  `RBRS_ASSERT_ALWAYS(a_clear_quiet, (!rst_n |=> !in_ready), "command taken during clear")
endmodule

/* verif/rotating_backup_record_store_tb.sv */
// ----------------------------------------------------------------------------
// rotating_backup_record_store_tb
// self-checking bench: commands go in on a valid/ready channel, a local model
// of the cell ring predicts every result beat, which is compared on arrival
// ----------------------------------------------------------------------------
module rotating_backup_record_store_tb;
  import rbrs_pkg::*;

  localparam int unsigned STORE_SIZE = 4096;
  localparam int unsigned REC_MAX    = 32;
  localparam int unsigned PERIOD     = 12;
  localparam logic [1:0]  OP_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
  } cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;

  rbrs_stream_if #(.payload_t(cmd_t))    cmd_if ();
  rbrs_stream_if #(.payload_t(result_t)) res_if ();

  // flat result wires gathered into the result channel payload
  logic [1:0] o_status;
  logic [7:0] o_byte;
  logic       o_bvalid;
  logic [7:0] o_stale;
  logic       o_last;
  assign res_if.payload = '{status: o_status, read_byte: o_byte, byte_valid: o_bvalid,
                            bad_cells: o_stale, last: o_last};

  rotating_backup_record_store DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (cmd_if.valid),
    .in_ready        (cmd_if.ready),
    .in_opcode       (cmd_if.payload.opcode),
    .in_byte_index   (cmd_if.payload.byte_index),
    .in_data_byte    (cmd_if.payload.data_byte),
    .out_valid       (res_if.valid),
    .out_ready       (res_if.ready),
    .out_status      (o_status),
    .out_read_byte   (o_byte),
    .out_byte_valid  (o_bvalid),
    .out_bad_cells   (o_stale),
    .out_last        (o_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------- model state
  logic [7:0]  mirror [STORE_SIZE];
  logic [7:0]  staged [REC_MAX];
  int unsigned ofs_reg;
  int unsigned depth_reg;
  int unsigned len_reg;

  result_t     pending_beats [$];
  int unsigned fail_count;
  int unsigned beats_seen;
  int unsigned saves_sent;
  int unsigned restores_sent;
  bit          calm;   // no idling on either side while set

  function automatic logic [7:0] mirror_rd(int unsigned a);
    return (a < STORE_SIZE) ? mirror[a] : ERASED;
  endfunction

  function automatic void mirror_wr(int unsigned a, logic [7:0] v);
    if (a < STORE_SIZE) mirror[a] = v;
  endfunction

  function automatic int unsigned cell_addr(int unsigned idx);
    return ofs_reg + idx * (HDR_BYTES + len_reg);
  endfunction

  // checksum test of one cell; a failing cell is marked erased
  function automatic bit cell_intact(int unsigned idx);
    int unsigned base;
    int unsigned sum;
    int unsigned kept;
    base = cell_addr(idx);
    sum  = mirror_rd(base);
    for (int unsigned i = 0; i < len_reg; i++) sum += mirror_rd(base + HDR_BYTES + i);
    sum &= 16'hFFFF;
    kept = {mirror_rd(base + 2), mirror_rd(base + 1)};
    if (sum == kept) return 1'b1;
    mirror_wr(base, ERASED);
    return 1'b0;
  endfunction

  // newest valid cell, freshness wrapping around the top of the byte range
  function automatic int unsigned newest_cell(output logic [7:0] stale,
                                              output int unsigned fresh);
    int unsigned best;
    int unsigned bestf;
    int unsigned f;
    bit          newer;
    best  = depth_reg;
    bestf = 255;
    stale = '0;
    for (int unsigned idx = 0; idx < depth_reg; idx++) begin
      f = mirror_rd(cell_addr(idx));
      newer = 1'b0;
      if (f != 255) begin
        if (bestf == 255) newer = 1'b1;
        else if (f > 255 - depth_reg && bestf < depth_reg) newer = 1'b0;
        else if (f > bestf) newer = 1'b1;
        else if (f < depth_reg && bestf > 255 - depth_reg) newer = 1'b1;
        if (newer) begin
          if (cell_intact(idx)) begin
            best  = idx;
            bestf = f;
          end else begin
            stale = stale + 8'd1;
          end
        end
      end
    end
    fresh = bestf;
    return best;
  endfunction

  function automatic logic [1:0] param_fault();
    if (depth_reg == 0 || depth_reg >= DEPTH_LIMIT) return ST_BAD_LEN;
    if (ofs_reg >= STORE_SIZE) return ST_BAD_OFS;
    if (len_reg > REC_MAX) return ST_BAD_LEN;
    if (ofs_reg + depth_reg * (HDR_BYTES + len_reg) >= STORE_SIZE) return ST_BAD_LEN;
    return ST_OK;
  endfunction

  function automatic result_t mk_beat(logic [1:0] st, logic [7:0] b, logic v,
                                      logic [7:0] sc, logic l);
    return '{status: st, read_byte: b, byte_valid: v, bad_cells: sc, last: l};
  endfunction

  // works out the result beats of one accepted command
  function automatic void predict_cmd(cmd_t c);
    logic [1:0]  err;
    logic [7:0]  stale;
    int unsigned fresh;
    int unsigned idx;
    int unsigned base;
    int unsigned sum;
    case (c.opcode)
      OP_STAGE: begin
        staged[c.byte_index] = c.data_byte;
        pending_beats.push_back(mk_beat(ST_OK, 8'd0, 1'b0, 8'd0, 1'b1));
      end
      OP_SAVE, OP_RESTORE: begin
        err = param_fault();
        if (err != ST_OK) begin
          pending_beats.push_back(mk_beat(err, 8'd0, 1'b0, 8'd0, 1'b1));
        end else begin
          idx = newest_cell(stale, fresh);
          if (c.opcode == OP_SAVE) begin
            if (idx < depth_reg) begin
              idx = (idx + 1 >= depth_reg) ? 0 : idx + 1;
              fresh = (fresh + 1 >= 255) ? 0 : fresh + 1;
            end else begin
              idx = 0;
              fresh = 0;
            end
            base = cell_addr(idx);
            sum = fresh;
            for (int unsigned i = 0; i < len_reg; i++) begin
              mirror_wr(base + HDR_BYTES + i, staged[i]);
              sum += staged[i];
            end
            mirror_wr(base + 1, sum[7:0]);
            mirror_wr(base + 2, sum[15:8]);
            mirror_wr(base, fresh[7:0]);
            pending_beats.push_back(mk_beat(ST_OK, 8'd0, 1'b0, stale, 1'b1));
          end else if (idx >= depth_reg) begin
            pending_beats.push_back(mk_beat(ST_NO_CELL, 8'd0, 1'b0, 8'hFF, 1'b1));
          end else if (len_reg == 0) begin
            pending_beats.push_back(mk_beat(ST_OK, 8'd0, 1'b0, stale, 1'b1));
          end else begin
            base = cell_addr(idx);
            for (int unsigned i = 0; i < len_reg; i++)
              pending_beats.push_back(mk_beat(ST_OK, mirror_rd(base + HDR_BYTES + i), 1'b1,
                                              stale, i + 1 == len_reg));
          end
        end
      end
      default: ;  // unused opcode, dropped
    endcase
  endfunction

  // ---------------------------------------------------------------- result side
  // random backpressure, none while calm
  always @(posedge clk) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  // each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", res_if.payload);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (res_if.payload.status != want.status) begin
          $error("status expected %0d got %0d", want.status, res_if.payload.status);
          fail_count++;
        end
        if (res_if.payload.read_byte != want.read_byte) begin
          $error("read_byte expected %0h got %0h", want.read_byte, res_if.payload.read_byte);
          fail_count++;
        end
        if (res_if.payload.byte_valid != want.byte_valid) begin
          $error("byte_valid expected %0d got %0d", want.byte_valid,
                 res_if.payload.byte_valid);
          fail_count++;
        end
        if (res_if.payload.bad_cells != want.bad_cells) begin
          $error("bad_cells expected %0d got %0d", want.bad_cells,
                 res_if.payload.bad_cells);
          fail_count++;
        end
        if (res_if.payload.last != want.last) begin
          $error("last expected %0d got %0d", want.last, res_if.payload.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drive tasks
  // all tasks start and end just after a rising edge

  // one command beat; valid is left high so back-to-back beats need no drop
  task automatic send_cmd(logic [1:0] op, logic [4:0] bi, logic [7:0] db);
    cmd_t c;
    c = '{opcode: op, byte_index: bi, data_byte: db};
    if (!calm && $urandom_range(0, 99) < 20) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_cmd(c);
    if (op == OP_SAVE) saves_sent++;
    if (op == OP_RESTORE) restores_sent++;
  endtask

  // drop valid and hold off until every predicted beat has come back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    // a dropped opcode may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET: ofs_reg   = val;
      REG_DEPTH:  depth_reg = val[7:0];
      REG_LENGTH: len_reg   = val[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ring(int unsigned o, int unsigned d, int unsigned l);
    drain();
    cfg_write(REG_OFFSET, o[11:0]);
    cfg_write(REG_DEPTH, d[11:0]);
    cfg_write(REG_LENGTH, l[11:0]);
  endtask

  // ---------------------------------------------------------------- tests
  // erased store after reset: restore finds nothing, then an empty record
  task automatic test_erased_store();
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    send_cmd(OP_NONE, 5'h1F, 8'hFF);
  endtask

  // every staging slot gets written, edge values first, with no idling
  task automatic test_stage_fill();
    calm = 1'b1;
    send_cmd(OP_STAGE, 5'd0, 8'h00);
    send_cmd(OP_STAGE, 5'd31, 8'hFF);
    for (int i = 1; i < 31; i++) send_cmd(OP_STAGE, i[4:0], 8'($urandom_range(0, 255)));
    calm = 1'b0;
  endtask

  // depth, record length and region-end faults in turn
  task automatic test_param_faults();
    set_ring(0, 0, 4);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    set_ring(0, 86, 4);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    set_ring(0, 255, 0);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    set_ring(0, 2, 63);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    set_ring(4095, 1, 0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
  endtask

  // full-length records around a small ring, then the largest legal ring
  task automatic test_full_records();
    set_ring(0, 3, 32);
    repeat (4) send_cmd(OP_SAVE, 5'd0, 8'd0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    set_ring(4096 - 85 * 35 - 1, 85, 32);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    set_ring(4096 - 85 * 35 - 1, 85, 31);  // shorter view breaks every checksum
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
  endtask

  // a record whose data reads as a cell of freshness 0xFE under a narrower
  // ring, so the next saves roll the freshness back through 0
  task automatic test_freshness_wrap();
    set_ring(0, 1, 32);
    send_cmd(OP_STAGE, 5'd0, 8'hFE);
    send_cmd(OP_STAGE, 5'd1, 8'hFE);
    send_cmd(OP_STAGE, 5'd2, 8'h00);
    send_cmd(OP_STAGE, 5'd3, 8'hFF);
    send_cmd(OP_STAGE, 5'd4, 8'hFF);
    send_cmd(OP_STAGE, 5'd5, 8'hFF);
    send_cmd(OP_SAVE, 5'd0, 8'd0);
    set_ring(3, 2, 0);
    repeat (3) send_cmd(OP_SAVE, 5'd0, 8'd0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
    set_ring(3, 3, 1);
    repeat (2) send_cmd(OP_SAVE, 5'd0, 8'd0);
    send_cmd(OP_RESTORE, 5'd0, 8'd0);
  endtask

  // random rings and command mixes, mostly small rings
  task automatic test_random_mix();
    int unsigned o;
    int unsigned d;
    int unsigned l;
    int unsigned pick;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        o = 0; d = 85; l = 32;
      end else begin
        d = $urandom_range(1, 6);
        l = $urandom_range(0, 8);
        o = $urandom_range(0, 4000 - d * (3 + l));
        if ($urandom_range(0, 3) == 0) o = ofs_reg;  // reuse the region, stale cells
      end
      set_ring(o, d, l);
      for (int n = 0; n < (phase == 3 ? 4 : 8); n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_cmd(OP_STAGE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        else if (pick < 72) send_cmd(OP_SAVE, 5'($urandom), 8'($urandom));
        else if (pick < 95) send_cmd(OP_RESTORE, 5'($urandom), 8'($urandom));
        else send_cmd(OP_NONE, 5'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    for (int i = 0; i < STORE_SIZE; i++) mirror[i] = ERASED;
    for (int i = 0; i < REC_MAX; i++) staged[i] = 8'd0;
    ofs_reg = 0; depth_reg = 2; len_reg = 0;
    fail_count = 0; beats_seen = 0; saves_sent = 0; restores_sent = 0;
    calm = 1'b0;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_OFFSET; cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.payload = '0;
    res_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_erased_store();
    test_stage_fill();
    drain();  // sender waits for every result before moving on
    test_param_faults();
    test_full_records();
    test_freshness_wrap();
    test_random_mix();

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d saves, %0d restores, %0d result beats checked",
             saves_sent, restores_sent, beats_seen);
    $display("rings from 1 to 85 cells, records of 0 to 32 bytes, freshness roll-over, "
             + "all parameter faults");
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(PERIOD * 6_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
